[rtl/fvg_pkg.sv]
package fvg_pkg;

    // partition table layout
    localparam int PARTITION_SLOTS = 4;
    localparam int ENTRY_BYTES     = 16;
    localparam logic [8:0] TABLE_BASE = 9'h1BE;
    localparam logic [9:0] TABLE_END  = 10'(int'(TABLE_BASE) + ENTRY_BYTES * PARTITION_SLOTS);
    localparam logic [3:0] POS_TYPE      = 4'd4;
    localparam logic [3:0] POS_LAST      = 4'd15;
    localparam logic [1:0] POS_START_HI  = 2'd2;
    localparam logic [1:0] POS_SIZE_HI   = 2'd3;
    localparam logic [7:0] FAT32_TYPE    = 8'h0B;
    localparam int COUNT_W = 3;

    // boot sector field offsets
    localparam logic [8:0] OFF_CLUSTER_SECTORS = 9'h00D;
    localparam logic [8:0] OFF_FAT_COPIES      = 9'h010;
    localparam logic [8:0] OFF_RESERVED        = 9'h00E;
    localparam logic [8:0] OFF_FAT_LENGTH      = 9'h024;
    localparam logic [8:0] OFF_ROOT            = 9'h02C;
    localparam logic [8:0] OFF_SECTOR_LAST     = 9'h1FF;

    // fat entries per sector is 2^FAT_SHIFT
    localparam int FAT_SHIFT = 7;

    typedef enum logic [1:0] {
        KIND_TABLE   = 2'd0,
        KIND_BOOT    = 2'd1,
        KIND_CLUSTER = 2'd2,
        KIND_FAT     = 2'd3
    } fvg_kind_t;

    // geometry as seen by one item
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [31:0]        first_start;
        logic [31:0]        first_size;
        logic [7:0]         cluster_sectors;
        logic [7:0]         fat_copies;
        logic [15:0]        reserved_count;
        logic [31:0]        fat_length;
        logic [31:0]        root_start;
    } fvg_snap_t;

    // one queued job for the back end
    typedef struct packed {
        fvg_kind_t  kind;
        logic [31:0] cluster;
        logic [7:0]  sector_in_cluster;
        fvg_snap_t   snap;
    } fvg_job_t;

endpackage

[rtl/fat32_volume_geometry_unit.sv]
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_stall  | kind, byte_offset, data_byte, cluster,
//          |                      | sector_in_cluster
// output   | out_valid / out_stall| result_kind .. entry_offset (one per query or
//          |                      | per sector byte at offset 511)
//
// one item per cycle while in_stall is low; the front captures one field byte per item
// a result leaves after its item has passed, in order: queue, product
// stage, sum stage, output register
// rst_n clears all captured geometry and the queue; no sweep after reset
// in_stall rises only when the two-entry queue is full, so output stalls reach
// the input after the pipeline and queue have filled
module fat32_volume_geometry_unit import fvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [8:0]  byte_offset,
    input  logic [7:0]  data_byte,
    input  logic [31:0] cluster,
    input  logic [7:0]  sector_in_cluster,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [2:0]  partition_count,
    output logic [31:0] partition_start,
    output logic [31:0] partition_size,
    output logic [31:0] fat_sector,
    output logic [31:0] data_sector,
    output logic [31:0] root_cluster,
    output logic [7:0]  cluster_sectors,
    output logic [31:0] sector_address,
    output logic [8:0]  entry_offset
);

    logic     accept, push, full, head_valid, pop;
    fvg_job_t push_job, head_job;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    // capture and classify
    fvg_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .kind              (kind),
        .byte_offset       (byte_offset),
        .data_byte         (data_byte),
        .cluster           (cluster),
        .sector_in_cluster (sector_in_cluster),
        .push              (push),
        .job               (push_job)
    );

    // decoupling queue
    fvg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    // address arithmetic
    fvg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .partition_count (partition_count),
        .partition_start (partition_start),
        .partition_size  (partition_size),
        .fat_sector      (fat_sector),
        .data_sector     (data_sector),
        .root_cluster    (root_cluster),
        .cluster_sectors (cluster_sectors),
        .sector_address  (sector_address),
        .entry_offset    (entry_offset)
    );

endmodule

[rtl/fvg_front.sv]
module fvg_front import fvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  kind,
    input  logic [8:0]  byte_offset,
    input  logic [7:0]  data_byte,
    input  logic [31:0] cluster,
    input  logic [7:0]  sector_in_cluster,
    output logic        push,
    output fvg_job_t    job
);

    fvg_snap_t   snap_reg, snap_next;
    logic        match_reg, match_next;
    logic [31:0] start_acc_reg, start_acc_next;
    logic [31:0] size_acc_reg, size_acc_next;
    fvg_kind_t   kind_in;
    logic        in_table;
    logic [8:0]  rel;
    logic [3:0]  pos;

    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

    assign kind_in  = fvg_kind_t'(kind);
    assign rel      = byte_offset - TABLE_BASE;
    assign pos      = rel[3:0];
    assign in_table = (byte_offset >= TABLE_BASE) && ({1'b0, byte_offset} < TABLE_END);

    // field capture
    always_comb
    begin
        snap_next      = snap_reg;
        match_next     = match_reg;
        start_acc_next = start_acc_reg;
        size_acc_next  = size_acc_reg;
        if (accept)
        begin
            case (kind_in)
                KIND_TABLE:
                begin
                    if (byte_offset == '0)
                    begin
                        snap_next.count       = '0;
                        snap_next.first_start = '0;
                        snap_next.first_size  = '0;
                    end
                    if (in_table)
                    begin
                        if (pos == POS_TYPE)
                            match_next = (data_byte == FAT32_TYPE);
                        else if (pos[3:2] == POS_START_HI)
                            start_acc_next = put_byte(start_acc_reg, pos[1:0], data_byte);
                        else if (pos[3:2] == POS_SIZE_HI)
                            size_acc_next = put_byte(size_acc_reg, pos[1:0], data_byte);
                        // entry complete: judge it
                        if (pos == POS_LAST && match_reg)
                        begin
                            if (snap_next.count == '0)
                            begin
                                snap_next.first_start = start_acc_next;
                                snap_next.first_size  = size_acc_next;
                            end
                            if (snap_next.count < COUNT_W'(PARTITION_SLOTS))
                                snap_next.count = snap_next.count + COUNT_W'(1);
                        end
                    end
                end
                KIND_BOOT:
                begin
                    if (byte_offset == OFF_CLUSTER_SECTORS)
                        snap_next.cluster_sectors = data_byte;
                    else if (byte_offset == OFF_FAT_COPIES)
                        snap_next.fat_copies = data_byte;
                    else if (byte_offset[8:1] == OFF_RESERVED[8:1])
                    begin
                        if (byte_offset[0])
                            snap_next.reserved_count[15:8] = data_byte;
                        else
                            snap_next.reserved_count[7:0] = data_byte;
                    end
                    else if (byte_offset[8:2] == OFF_FAT_LENGTH[8:2])
                        snap_next.fat_length = put_byte(snap_reg.fat_length, byte_offset[1:0],
                                                        data_byte);
                    else if (byte_offset[8:2] == OFF_ROOT[8:2])
                        snap_next.root_start = put_byte(snap_reg.root_start, byte_offset[1:0],
                                                        data_byte);
                end
                default:
                begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg      <= '0;
            match_reg     <= 1'b0;
            start_acc_reg <= '0;
            size_acc_reg  <= '0;
        end
        else
        begin
            snap_reg      <= snap_next;
            match_reg     <= match_next;
            start_acc_reg <= start_acc_next;
            size_acc_reg  <= size_acc_next;
        end
    end

    // classify: queries and last sector bytes give a result
    assign push = accept && ((kind_in == KIND_CLUSTER) || (kind_in == KIND_FAT)
                             || (byte_offset == OFF_SECTOR_LAST));

    assign job.kind              = kind_in;
    assign job.cluster           = cluster;
    assign job.sector_in_cluster = sector_in_cluster;
    assign job.snap              = snap_next;

endmodule

[rtl/fvg_queue.sv]
module fvg_queue import fvg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fvg_job_t push_job,
    output logic     full,
    output logic     head_valid,
    input  logic     pop,
    output fvg_job_t head_job
);

    fvg_job_t   slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

[rtl/fvg_back.sv]
module fvg_back import fvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  fvg_job_t    head_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [2:0]  partition_count,
    output logic [31:0] partition_start,
    output logic [31:0] partition_size,
    output logic [31:0] fat_sector,
    output logic [31:0] data_sector,
    output logic [31:0] root_cluster,
    output logic [7:0]  cluster_sectors,
    output logic [31:0] sector_address,
    output logic [8:0]  entry_offset
);

    // stage one: products and fat start
    logic        v1_reg;
    fvg_kind_t   k1_reg;
    logic [31:0] cl1_reg;
    logic [7:0]  sic1_reg;
    fvg_snap_t   sn1_reg;
    logic [31:0] fat1_reg, fprod1_reg, cprod1_reg;
    // stage two: data start and partial addresses
    logic        v2_reg;
    fvg_kind_t   k2_reg;
    fvg_snap_t   sn2_reg;
    logic [31:0] fat2_reg, data2_reg, coff2_reg, faddr2_reg;
    logic [8:0]  eoff2_reg;
    // stage three: output register
    logic        v3_reg;

    logic en1, en2, en3;

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = head_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= head_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage one
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            k1_reg     <= head_job.kind;
            cl1_reg    <= head_job.cluster;
            sic1_reg   <= head_job.sector_in_cluster;
            sn1_reg    <= head_job.snap;
            fat1_reg   <= head_job.snap.first_start + {16'd0, head_job.snap.reserved_count};
            fprod1_reg <= 32'({24'd0, head_job.snap.fat_copies} * head_job.snap.fat_length);
            cprod1_reg <= 32'({24'd0, head_job.snap.cluster_sectors} * head_job.cluster);
        end
    end

    // stage two: spc * (cluster - 2) + sic as product minus twice spc
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            k2_reg     <= k1_reg;
            sn2_reg    <= sn1_reg;
            fat2_reg   <= fat1_reg;
            data2_reg  <= fat1_reg + fprod1_reg;
            coff2_reg  <= cprod1_reg - {23'd0, sn1_reg.cluster_sectors, 1'b0}
                          + {24'd0, sic1_reg};
            faddr2_reg <= fat1_reg + (cl1_reg >> FAT_SHIFT);
            eoff2_reg  <= {cl1_reg[FAT_SHIFT-1:0], 2'b00};
        end
    end

    // stage three: result register
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            result_kind     <= k2_reg;
            partition_count <= sn2_reg.count;
            partition_start <= sn2_reg.first_start;
            partition_size  <= sn2_reg.first_size;
            fat_sector      <= fat2_reg;
            data_sector     <= data2_reg;
            root_cluster    <= sn2_reg.root_start;
            cluster_sectors <= sn2_reg.cluster_sectors;
            case (k2_reg)
                KIND_CLUSTER:
                begin
                    sector_address <= data2_reg + coff2_reg;
                    entry_offset   <= '0;
                end
                KIND_FAT:
                begin
                    sector_address <= faddr2_reg;
                    entry_offset   <= eoff2_reg;
                end
                default:
                begin
                    sector_address <= '0;
                    entry_offset   <= '0;
                end
            endcase
        end
    end

    assign out_valid = v3_reg;

endmodule
